>>> rtl/lcssr_pkg.sv
// Package for the laser current soft-start ramp block.
// Holds field widths, register indexes, reset values and duty constants.
// No dependencies.
package lcssr_pkg;

  localparam int DUTY_FRAC_BITS = 8;

  localparam int CUR_W   = 15;
  localparam int REQ_W   = 16;
  localparam int STEP_W  = 12;
  localparam int GAIN_W  = 16;
  localparam int SUP_W   = 13;
  localparam int DUTY_W  = 15;
  localparam int CLS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W  = CUR_W + GAIN_W;

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100 << DUTY_FRAC_BITS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LVL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOS_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN  = 3'd6;

  // Ramp classes
  localparam logic [CLS_W-1:0] CLS_BEACON = 2'd1;
  localparam logic [CLS_W-1:0] CLS_SOS    = 2'd2;

  // Register reset values
  localparam logic [CUR_W-1:0]  RST_JUMP_THR    = 15'd600;
  localparam logic [CUR_W-1:0]  RST_START_LVL   = 15'd600;
  localparam logic [STEP_W-1:0] RST_DEF_STEP    = 12'd2;
  localparam logic [STEP_W-1:0] RST_BEACON_STEP = 12'd1000;
  localparam logic [STEP_W-1:0] RST_SOS_STEP    = 12'd400;
  localparam logic [STEP_W-1:0] RST_BURN_STEP   = 12'd50;
  localparam logic [GAIN_W-1:0] RST_DUTY_GAIN   = 16'd11707;

endpackage

>>> rtl/laser_current_soft_start_ramp_top.sv
// Laser diode current soft-start ramp with PWM duty computation.
// Flow: the result goes straight to the output register when the current holds or the
//   driver turns off; a new duty takes a serial multiply, a saturation check, a serial
//   divide (skipped on saturation) and the output load; a new item waits for that load.
// Reset: rst_ni asynchronous active low; clears ramp state, held duty and control,
//   and loads the configuration registers with their default values.
module laser_current_soft_start_ramp_top import lcssr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [REQ_W-1:0]       requested_ma_i,
  input  logic [CUR_W-1:0]       thermal_limit_ma_i,
  input  logic                   burn_active_i,
  input  logic [CLS_W-1:0]       ramp_class_i,
  input  logic [SUP_W-1:0]       supply_mv_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DUTY_W-1:0]      duty_q8_o,
  output logic                   driver_enable_o,
  output logic [CUR_W-1:0]       applied_ma_o,
  output logic                   updated_o
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DUTY_W - 1);

  // Configuration registers
  logic [CUR_W-1:0]  jump_thr_q, start_lvl_q;
  logic [STEP_W-1:0] def_step_q, beacon_step_q, sos_step_q, burn_step_q;
  logic [GAIN_W-1:0] duty_gain_q;

  // Ramp state
  logic [CUR_W-1:0]  applied_q, applied_d;
  logic              ramping_q, ramping_d;
  logic              driver_on_q, driver_on_d;
  logic [DUTY_W-1:0] held_duty_q;
  logic              upd_q;

  // Sequencer and serial datapath
  logic [2:0]        state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUP_W-1:0]  supply_q;
  logic [PROD_W-1:0] acc_q;     // product accumulator
  logic [PROD_W-1:0] mcand_q;   // shifted multiplicand
  logic [GAIN_W-1:0] mplier_q;  // gain, consumed LSB first
  logic [SUP_W-1:0]  rem_q;
  logic [DUTY_W-1:0] quo_q;

  // Output register
  logic              out_valid_q;
  logic [DUTY_W-1:0] out_duty_q;
  logic              out_en_q;
  logic [CUR_W-1:0]  out_applied_q;
  logic              out_upd_q;

  logic in_xfer;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Ramp step: target, jump detect and next applied current for one tick
  // ---------------------------------------------------------------------------
  logic              req_pos;
  logic [CUR_W-1:0]  tgt;
  logic              tgt_pos;
  logic              same;
  logic              jump;
  logic              ramp_now;
  logic [STEP_W-1:0] step;
  logic [CUR_W:0]    next_cur;
  logic [CUR_W:0]    thr_sum;
  logic              needs_duty;

  always_comb begin
    req_pos = !requested_ma_i[REQ_W-1] && (requested_ma_i != '0);
    // cap positive request by the thermal limit
    if (req_pos && (REQ_W'(thermal_limit_ma_i) < requested_ma_i)) begin
      tgt = thermal_limit_ma_i;
    end else begin
      tgt = requested_ma_i[CUR_W-1:0];
    end
    // a thermal limit of zero turns a positive request into an off request
    tgt_pos = req_pos && (tgt != '0);
    // negative request never matches the applied current
    if (req_pos) begin
      same = (tgt == applied_q);
    end else begin
      same = (requested_ma_i == '0) && (applied_q == '0);
    end

    thr_sum  = {1'b0, applied_q} + {1'b0, jump_thr_q};
    jump     = {1'b0, tgt} > thr_sum;
    ramp_now = ramping_q || jump;

    // burn wins over the ramp class; class 3 falls to the default step
    if (burn_active_i) begin
      step = burn_step_q;
    end else if (ramp_class_i == CLS_BEACON) begin
      step = beacon_step_q;
    end else if (ramp_class_i == CLS_SOS) begin
      step = sos_step_q;
    end else begin
      step = def_step_q;
    end

    if (applied_q == '0) begin
      next_cur = {1'b0, (tgt < start_lvl_q) ? tgt : start_lvl_q};
    end else begin
      next_cur = {1'b0, applied_q} + (CUR_W+1)'(step);
    end

    applied_d   = applied_q;
    ramping_d   = ramping_q;
    driver_on_d = driver_on_q;
    needs_duty  = 1'b0;
    if (!same) begin
      if (tgt_pos) begin
        driver_on_d = 1'b1;
        needs_duty  = 1'b1;
        if (ramp_now) begin
          // clamp at target and end the ramp once reached
          if (next_cur >= {1'b0, tgt}) begin
            ramping_d = 1'b0;
            applied_d = tgt;
          end else begin
            ramping_d = 1'b1;
            applied_d = next_cur[CUR_W-1:0];
          end
        end else begin
          applied_d = tgt;
        end
      end else begin
        // off path: ramping bit is kept
        driver_on_d = 1'b0;
        applied_d   = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Division step: one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [SUP_W:0]    trial;
  logic              qbit;
  logic [SUP_W-1:0]  rem_next;
  logic [DUTY_W-1:0] quo_next;
  logic [DUTY_W-1:0] quo_clamped;

  always_comb begin
    trial    = {rem_q, quo_q[DUTY_W-1]};
    qbit     = trial >= {1'b0, supply_q};
    rem_next = qbit ? SUP_W'(trial - {1'b0, supply_q}) : trial[SUP_W-1:0];
    quo_next = {quo_q[DUTY_W-2:0], qbit};
    quo_clamped = (quo_next > DUTY_FULL) ? DUTY_FULL : quo_next;
  end

  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_thr_q    <= RST_JUMP_THR;
      start_lvl_q   <= RST_START_LVL;
      def_step_q    <= RST_DEF_STEP;
      beacon_step_q <= RST_BEACON_STEP;
      sos_step_q    <= RST_SOS_STEP;
      burn_step_q   <= RST_BURN_STEP;
      duty_gain_q   <= RST_DUTY_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_JUMP_THR:    jump_thr_q    <= cfg_data_i[CUR_W-1:0];
        REG_START_LVL:   start_lvl_q   <= cfg_data_i[CUR_W-1:0];
        REG_DEF_STEP:    def_step_q    <= cfg_data_i[STEP_W-1:0];
        REG_BEACON_STEP: beacon_step_q <= cfg_data_i[STEP_W-1:0];
        REG_SOS_STEP:    sos_step_q    <= cfg_data_i[STEP_W-1:0];
        REG_BURN_STEP:   burn_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_DUTY_GAIN:   duty_gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, ramp state and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      applied_q   <= '0;
      ramping_q   <= 1'b0;
      driver_on_q <= 1'b0;
      held_duty_q <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            applied_q   <= applied_d;
            ramping_q   <= ramping_d;
            driver_on_q <= driver_on_d;
            upd_q       <= !same;
            if (!same && !tgt_pos) begin
              held_duty_q <= '0;
            end
            cnt_q   <= '0;
            state_q <= needs_duty ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          cnt_q <= '0;
          // quotient of 2^15 or more, or zero supply: saturate at full scale
          if (acc_q >= {{(PROD_W-SUP_W-DUTY_W){1'b0}}, supply_q, {DUTY_W{1'b0}}}) begin
            held_duty_q <= DUTY_FULL;
            state_q     <= S_DONE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_LAST) begin
            held_duty_q <= quo_clamped;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Serial datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          supply_q <= supply_mv_i;
          acc_q    <= '0;
          mcand_q  <= PROD_W'(applied_d);
          mplier_q <= duty_gain_q;
        end
      end
      S_MUL: begin
        // add one partial product per cycle, gain LSB first
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[GAIN_W-1:1]};
      end
      S_SAT: begin
        // upper product bits are below the supply here
        rem_q <= acc_q[SUP_W+DUTY_W-1:DUTY_W];
        quo_q <= acc_q[DUTY_W-1:0];
      end
      S_DIV: begin
        // shift dividend bits out as quotient bits shift in
        rem_q <= rem_next;
        quo_q <= quo_next;
      end
      default: ;
    endcase
    if (out_load) begin
      out_duty_q    <= held_duty_q;
      out_en_q      <= driver_on_q;
      out_applied_q <= applied_q;
      out_upd_q     <= upd_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign duty_q8_o       = out_duty_q;
  assign driver_enable_o = out_en_q;
  assign applied_ma_o    = out_applied_q;
  assign updated_o       = out_upd_q;

endmodule

>>> rtl/lcssr_checker.sv
// Port-level checker for the laser current soft-start ramp top level.
// Depends on lcssr_pkg; bound to laser_current_soft_start_ramp_top below.
module lcssr_checker import lcssr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DUTY_W-1:0]     duty_q8_o,
  input logic                  driver_enable_o,
  input logic [CUR_W-1:0]      applied_ma_o,
  input logic                  updated_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(duty_q8_o)
      && $stable(applied_ma_o) && $stable(driver_enable_o) && $stable(updated_o)))
    else $error("stalled result changed");

  // duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_q8_o <= DUTY_FULL))
    else $error("duty above full scale");

  // driver off means no current and no duty
  a_off_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !driver_enable_o) |-> (applied_ma_o == '0 && duty_q8_o == '0))
    else $error("driver off with current or duty");

  // a result follows each transfer and no transfer is taken in the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after transfer");

endmodule

bind laser_current_soft_start_ramp_top lcssr_checker u_lcssr_checker (.*);

>>> bench/laser_current_soft_start_ramp_top_tb.sv
// Self-checking bench for laser_current_soft_start_ramp_top: directed table, then random
// control ticks under several register settings, with a ramp and duty predictor.
// Depends on lcssr_pkg and the block itself; nothing else.
module laser_current_soft_start_ramp_top_tb;
  import lcssr_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int LONG_HOLD_AFTER = 400;
  localparam int LONG_HOLD_LEN   = 600;

  // Ramp class codes the package leaves unnamed
  localparam logic [CLS_W-1:0] CLS_ORDINARY = 2'd0;
  localparam logic [CLS_W-1:0] CLS_UNUSED   = 2'd3;

  typedef enum int {CFG_GENTLE, CFG_ZERO, CFG_RANDOM, CFG_FULL, CFG_DEFAULTS} cfg_kind_e;

  // One control tick as it crosses the input channel
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [CUR_W-1:0] lim;
    logic             burn;
    logic [CLS_W-1:0] cls;
    logic [SUP_W-1:0] sup;
  } tick_t;

  // One drive command as it leaves on the output channel
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              drv;
    logic [CUR_W-1:0]  cur;
    logic              upd;
  } drive_t;

  // Directed row: typed marks a hand-written answer in want
  typedef struct packed {
    tick_t  stim;
    logic   typed;
    drive_t want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [REQ_W-1:0]      requested_ma_i;
  logic [CUR_W-1:0]      thermal_limit_ma_i;
  logic                  burn_active_i;
  logic [CLS_W-1:0]      ramp_class_i;
  logic [SUP_W-1:0]      supply_mv_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [DUTY_W-1:0]     duty_q8_o;
  logic                  driver_enable_o;
  logic [CUR_W-1:0]      applied_ma_o;
  logic                  updated_o;

  laser_current_soft_start_ramp_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .requested_ma_i     (requested_ma_i),
    .thermal_limit_ma_i (thermal_limit_ma_i),
    .burn_active_i      (burn_active_i),
    .ramp_class_i       (ramp_class_i),
    .supply_mv_i        (supply_mv_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .duty_q8_o          (duty_q8_o),
    .driver_enable_o    (driver_enable_o),
    .applied_ma_o       (applied_ma_o),
    .updated_o          (updated_o)
  );

  // Shadow copy of the configuration registers, at their reset values
  logic [CUR_W-1:0]  jump_thr    = RST_JUMP_THR;
  logic [CUR_W-1:0]  start_lvl   = RST_START_LVL;
  logic [STEP_W-1:0] def_step    = RST_DEF_STEP;
  logic [STEP_W-1:0] beacon_step = RST_BEACON_STEP;
  logic [STEP_W-1:0] sos_step    = RST_SOS_STEP;
  logic [STEP_W-1:0] burn_step   = RST_BURN_STEP;
  logic [GAIN_W-1:0] duty_gain   = RST_DUTY_GAIN;

  // Predicted driver state
  logic [CUR_W-1:0]  applied_cur = '0;
  logic              ramp_armed  = 1'b0;
  logic              drv_on      = 1'b0;
  logic [DUTY_W-1:0] held_duty   = '0;

  drive_t owed_drive [$];   // drive commands still to come out, oldest first
  row_t   table_rows [$];
  drive_t want;
  int     mismatch_count = 0;
  int     results_seen   = 0;
  int     cycle_count    = 0;
  logic   long_hold_done = 1'b0;

  // Clock: period of 2 time units
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Duty in percent with DUTY_FRAC_BITS fraction bits, saturated at full scale
  function automatic logic [DUTY_W-1:0] duty_for(logic [CUR_W-1:0] cur,
                                                 logic [SUP_W-1:0] sup);
    longint unsigned q;
    if (sup == '0) return DUTY_FULL;
    q = (longint'(cur) * longint'(duty_gain)) / longint'(sup);
    if (q > longint'(DUTY_FULL)) q = longint'(DUTY_FULL);
    return q[DUTY_W-1:0];
  endfunction

  // Advance the ramp by one control tick and return the drive command it yields
  function automatic drive_t advance_ramp(tick_t t);
    drive_t r;
    int     target;
    int     nxt;
    int     stepv;
    target = int'($signed(t.req));
    // Cap only positive requests by the thermal limit
    if (target > 0 && int'(t.lim) < target) target = int'(t.lim);
    r.upd = 1'b0;
    if (target != int'(applied_cur)) begin
      r.upd = 1'b1;
      if (target > 0) begin
        if (target - int'(applied_cur) > int'(jump_thr)) ramp_armed = 1'b1;
        if (ramp_armed) begin
          if (applied_cur == '0) begin
            nxt = (target < int'(start_lvl)) ? target : int'(start_lvl);
          end else begin
            // Burn wins over the ramp class; unknown classes take the default step
            if (t.burn) stepv = int'(burn_step);
            else if (t.cls == CLS_BEACON) stepv = int'(beacon_step);
            else if (t.cls == CLS_SOS) stepv = int'(sos_step);
            else stepv = int'(def_step);
            nxt = int'(applied_cur) + stepv;
          end
          if (nxt >= target) begin
            ramp_armed = 1'b0;
            nxt = target;
          end
          applied_cur = CUR_W'(nxt);
        end else begin
          applied_cur = CUR_W'(target);
        end
        drv_on = 1'b1;
        held_duty = duty_for(applied_cur, t.sup);
      end else begin
        // Off path keeps the ramp flag
        drv_on = 1'b0;
        held_duty = '0;
        applied_cur = '0;
      end
    end
    r.duty = held_duty;
    r.drv  = drv_on;
    r.cur  = applied_cur;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic add_row(input int req, input int lim, input logic burn,
                         input logic [CLS_W-1:0] cls, input int sup, input logic typed,
                         input int duty, input logic drv, input int cur, input logic upd);
    row_t r;
    r.stim.req  = REQ_W'(req);
    r.stim.lim  = CUR_W'(lim);
    r.stim.burn = burn;
    r.stim.cls  = cls;
    r.stim.sup  = SUP_W'(sup);
    r.typed     = typed;
    r.want.duty = DUTY_W'(duty);
    r.want.drv  = drv;
    r.want.cur  = CUR_W'(cur);
    r.want.upd  = upd;
    table_rows.push_back(r);
  endtask

  // Sender gap: mostly back to back, some short, a few long
  function automatic int unsigned gap_len(input bit busy);
    int unsigned roll;
    if (busy) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Offer one tick after an optional gap; return at the edge that takes the transfer.
  // Valid is dropped only when a gap follows, so it never falls and rises in one step.
  task automatic send_tick(input tick_t t, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    requested_ma_i     <= t.req;
    thermal_limit_ma_i <= t.lim;
    burn_active_i      <= t.burn;
    ramp_class_i       <= t.cls;
    supply_mv_i        <= t.sup;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait until every owed command has come out, then let the pipeline go quiet
  task automatic settle();
    while (owed_drive.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all seven registers back to back and mirror them in the shadow copy
  task automatic program_config(input cfg_kind_e kind);
    logic [CFG_DATA_W-1:0] val;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  dflt;
    dflt = (kind == CFG_DEFAULTS);
    cfg_we_i <= 1'b1;
    for (int i = 0; i <= int'(REG_DUTY_GAIN); i++) begin
      idx = CFG_IDX_W'(i);
      case (kind)
        CFG_ZERO:   val = '0;
        CFG_FULL:   val = '1;
        CFG_RANDOM: val = CFG_DATA_W'($urandom_range(0, 65535));
        default: begin
          // Defaults, or a gentle setting where ramps finish in a sensible number of ticks
          case (idx)
            REG_JUMP_THR:    val = dflt ? CFG_DATA_W'(RST_JUMP_THR)
                                        : CFG_DATA_W'($urandom_range(0, 3000));
            REG_START_LVL:   val = dflt ? CFG_DATA_W'(RST_START_LVL)
                                        : CFG_DATA_W'($urandom_range(0, 3000));
            REG_DEF_STEP:    val = dflt ? CFG_DATA_W'(RST_DEF_STEP)
                                        : CFG_DATA_W'($urandom_range(1, 600));
            REG_BEACON_STEP: val = dflt ? CFG_DATA_W'(RST_BEACON_STEP)
                                        : CFG_DATA_W'($urandom_range(1, 600));
            REG_SOS_STEP:    val = dflt ? CFG_DATA_W'(RST_SOS_STEP)
                                        : CFG_DATA_W'($urandom_range(1, 600));
            REG_BURN_STEP:   val = dflt ? CFG_DATA_W'(RST_BURN_STEP)
                                        : CFG_DATA_W'($urandom_range(1, 600));
            default:         val = dflt ? CFG_DATA_W'(RST_DUTY_GAIN)
                                        : CFG_DATA_W'($urandom_range(1000, 40000));
          endcase
        end
      endcase
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      @(posedge clk_i);
      // Registers narrower than the data port keep only their low bits
      case (idx)
        REG_JUMP_THR:    jump_thr    = val[CUR_W-1:0];
        REG_START_LVL:   start_lvl   = val[CUR_W-1:0];
        REG_DEF_STEP:    def_step    = val[STEP_W-1:0];
        REG_BEACON_STEP: beacon_step = val[STEP_W-1:0];
        REG_SOS_STEP:    sos_step    = val[STEP_W-1:0];
        REG_BURN_STEP:   burn_step   = val[STEP_W-1:0];
        default:         duty_gain   = val[GAIN_W-1:0];
      endcase
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus: directed table first, then random phases under changing settings
  initial begin
    tick_t            t;
    drive_t           d;
    row_t             row;
    int               run;
    int               hold_req;
    int               hold_lim;
    int unsigned      roll;
    logic             hold_burn;
    logic [CLS_W-1:0] hold_cls;
    int               sent;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= '0;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    requested_ma_i     <= '0;
    thermal_limit_ma_i <= '0;
    burn_active_i      <= 1'b0;
    ramp_class_i       <= CLS_ORDINARY;
    supply_mv_i        <= '0;

    // Directed table, run with the reset register values.
    //       req    lim    brn cls           sup   typ duty   drv cur  upd
    // Zero request right after reset: nothing to change
    add_row(0,     1000,  0, CLS_ORDINARY, 3300, 1, 0,     0, 0,   0);
    // Negative request always takes the off path and flags an update
    add_row(-1,    32767, 0, CLS_ORDINARY, 3300, 1, 0,     0, 0,   1);
    // Small rise: follow the target at once
    add_row(100,   32767, 0, CLS_ORDINARY, 3300, 0, 0,     0, 0,   0);
    // Big rise: ramp through beacon, burn over beacon, SOS, class 3
    add_row(5000,  32767, 0, CLS_BEACON,   4000, 0, 0,     0, 0,   0);
    add_row(5000,  32767, 1, CLS_BEACON,   4000, 0, 0,     0, 0,   0);
    add_row(5000,  32767, 0, CLS_SOS,      4000, 0, 0,     0, 0,   0);
    add_row(5000,  32767, 0, CLS_UNUSED,   4000, 0, 0,     0, 0,   0);
    // Thermal cap pulls the target close: step overshoots and clamps
    add_row(5000,  1560,  0, CLS_BEACON,   4000, 0, 0,     0, 0,   0);
    // Same capped target again: hold everything
    add_row(1600,  1560,  0, CLS_ORDINARY, 4000, 0, 0,     0, 0,   0);
    // Thermal limit of zero turns a positive request off
    add_row(1000,  0,     0, CLS_ORDINARY, 4000, 1, 0,     0, 0,   1);
    // Full request from zero at 1 mV: start level, duty saturates
    add_row(32767, 32767, 0, CLS_ORDINARY, 1,    1, 25600, 1, 600, 1);
    // Zero supply: duty saturates
    add_row(32767, 32767, 0, CLS_ORDINARY, 0,    1, 25600, 1, 602, 1);
    // Off in mid-ramp; the ramp flag survives
    add_row(-1,    32767, 0, CLS_SOS,      6000, 1, 0,     0, 0,   1);
    add_row(400,   32767, 0, CLS_ORDINARY, 6000, 0, 0,     0, 0,   0);
    add_row(32767, 20000, 0, CLS_SOS,      6000, 0, 0,     0, 0,   0);
    add_row(32767, 20000, 1, CLS_SOS,      6000, 0, 0,     0, 0,   0);
    add_row(0,     20000, 0, CLS_ORDINARY, 6000, 1, 0,     0, 0,   1);
    add_row(0,     20000, 0, CLS_ORDINARY, 6000, 1, 0,     0, 0,   0);
    add_row(32767, 32767, 1, CLS_UNUSED,   6000, 0, 0,     0, 0,   0);
    // Rise at exactly the threshold, ramp still armed from before
    add_row(1200,  32767, 0, CLS_ORDINARY, 5461, 0, 0,     0, 0,   0);
    add_row(1200,  700,   0, CLS_ORDINARY, 5461, 0, 0,     0, 0,   0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[k]) begin
      row = table_rows[k];
      send_tick(row.stim, gap_len(1'b0));
      d = advance_ramp(row.stim);
      owed_drive.push_back(row.typed ? row.want : d);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Reconfigure only with the block idle
      in_valid_i <= 1'b0;
      settle();
      program_config(cfg_kind_e'(phase % 5));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Mostly hold one request for a run of ticks so ramps get somewhere;
        // the rest is single-tick noise
        roll = $urandom_range(0, 99);
        if (roll < 10) hold_req = -1;
        else if (roll < 18) hold_req = 0;
        else if (roll < 50) hold_req = $urandom_range(1, 1500);
        else hold_req = $urandom_range(1, 32767);
        roll = $urandom_range(0, 99);
        if (roll < 65) hold_lim = 32767;
        else if (roll < 85) hold_lim = $urandom_range(0, 32767);
        else hold_lim = $urandom_range(0, 2000);
        hold_burn = ($urandom_range(0, 3) == 0);
        hold_cls  = ($urandom_range(0, 9) == 0) ? CLS_UNUSED : CLS_W'($urandom_range(0, 2));
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 24) : 1;
        for (int k = 0; k < run && sent < ITEMS_PER_PHASE; k++) begin
          t.req  = REQ_W'(hold_req);
          t.lim  = ($urandom_range(0, 19) == 0) ? CUR_W'($urandom_range(0, 32767))
                                               : CUR_W'(hold_lim);
          t.burn = ($urandom_range(0, 9) == 0) ? ~hold_burn : hold_burn;
          t.cls  = hold_cls;
          roll = $urandom_range(0, 99);
          if (roll < 85) t.sup = SUP_W'($urandom_range(1, 6000));
          else if (roll < 95) t.sup = SUP_W'($urandom_range(1, 50));
          else t.sup = SUP_W'(6000);
          send_tick(t, gap_len(phase % 3 == 2));
          owed_drive.push_back(advance_ramp(t));
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("PASS laser_current_soft_start_ramp_top");
    end else begin
      $display("FAIL laser_current_soft_start_ramp_top");
    end
    $finish;
  end

  // Receiver: random ready pattern, plus one long hold-off to back up the input
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_LEN) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 20)) @(posedge clk_i);
        else repeat ($urandom_range(40, 200)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        if ($urandom_range(0, 99) < 70) repeat ($urandom_range(1, 3)) @(posedge clk_i);
        else if ($urandom_range(0, 9) < 8) repeat ($urandom_range(4, 20)) @(posedge clk_i);
        else repeat ($urandom_range(30, 100)) @(posedge clk_i);
      end
    end
  end

  // Checker: compare each transfer on the output with the oldest owed command
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (owed_drive.size() == 0) begin
        report_mismatch($sformatf("drive command with nothing owed: duty %0d cur %0d",
                                  duty_q8_o, applied_ma_o));
      end else begin
        want = owed_drive.pop_front();
        if (duty_q8_o !== want.duty)
          report_mismatch($sformatf("result %0d duty_q8 got %0d want %0d",
                                    results_seen, duty_q8_o, want.duty));
        if (driver_enable_o !== want.drv)
          report_mismatch($sformatf("result %0d driver_enable got %0b want %0b",
                                    results_seen, driver_enable_o, want.drv));
        if (applied_ma_o !== want.cur)
          report_mismatch($sformatf("result %0d applied_ma got %0d want %0d",
                                    results_seen, applied_ma_o, want.cur));
        if (updated_o !== want.upd)
          report_mismatch($sformatf("result %0d updated got %0b want %0b",
                                    results_seen, updated_o, want.upd));
      end
    end
  end

  // Watchdog: drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL laser_current_soft_start_ramp_top");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/lcssr_pkg.sv
rtl/laser_current_soft_start_ramp_top.sv
rtl/lcssr_checker.sv
bench/laser_current_soft_start_ramp_top_tb.sv
